@@ design/rgb_to_ansi_palette_code_defines.svh @@
// assertion macros shared by the palette code block
`ifndef RGB_TO_ANSI_PALETTE_CODE_DEFINES_SVH
`define RGB_TO_ANSI_PALETTE_CODE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ANSIPAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ANSIPAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ansipal_pkg.sv @@
// types, codes and helpers shared by the palette code block
package ansipal_pkg;

    typedef logic [7:0] chan_t;
    typedef logic [2:0] color_t;
    typedef logic [1:0] kind_t;

    // code kinds on the result
    localparam kind_t KIND_DIRECT = 2'd0;
    localparam kind_t KIND_FG_IDX = 2'd1;
    localparam kind_t KIND_BG_IDX = 2'd2;

    // palette mode register values
    localparam logic MODE_16  = 1'b0;
    localparam logic MODE_256 = 1'b1;

    // basic colour numbers
    localparam color_t COLOR_BLACK   = 3'd0;
    localparam color_t COLOR_RED     = 3'd1;
    localparam color_t COLOR_GREEN   = 3'd2;
    localparam color_t COLOR_YELLOW  = 3'd3;
    localparam color_t COLOR_BLUE    = 3'd4;
    localparam color_t COLOR_MAGENTA = 3'd5;
    localparam color_t COLOR_CYAN    = 3'd6;
    localparam color_t COLOR_WHITE   = 3'd7;

    // sgr bases and offsets
    localparam logic [7:0] SGR_NORMAL_BASE = 8'd30;
    localparam logic [7:0] SGR_BRIGHT_BASE = 8'd90;
    localparam logic [7:0] SGR_BG_OFFSET   = 8'd10;

    // luminance thresholds on r+g+b
    localparam logic [9:0] SUM_BRIGHT = 10'd306;
    localparam logic [9:0] SUM_WHITE  = 10'd612;

    // 256-colour palette anchors
    localparam logic [7:0] IDX_CUBE_BASE  = 8'd16;
    localparam logic [7:0] IDX_CUBE_TOP   = 8'd231;
    localparam logic [7:0] IDX_RAMP_BASE  = 8'd232;
    localparam logic [7:0] IDX_RAMP_SAT   = 8'd255;
    localparam logic [4:0] RAMP_STEP_LAST = 5'd24;
    localparam chan_t      RAMP_LOW       = 8'd8;
    localparam chan_t      RAMP_HIGH      = 8'd248;

    // result item on the output side
    typedef struct packed {
        logic [7:0] color_code;
        kind_t      code_kind;
    } result_t;

    // v*5/255, i.e. v/51, by threshold compares
    function automatic logic [2:0] cube_digit(input chan_t v);
        logic [2:0] d;
        if (v == 8'd255)
            d = 3'd5;
        else if (v >= 8'd204)
            d = 3'd4;
        else if (v >= 8'd153)
            d = 3'd3;
        else if (v >= 8'd102)
            d = 3'd2;
        else if (v >= 8'd51)
            d = 3'd1;
        else
            d = 3'd0;
        return d;
    endfunction

    // 5*x > 3*y, the exact form of x > 0.6*y
    function automatic logic over_six_tenths(input chan_t x, input chan_t y);
        logic [10:0] x5;
        logic [10:0] y3;
        x5 = {x, 2'b00} + {3'b000, x};
        y3 = {2'b00, y, 1'b0} + {3'b000, y};
        return x5 > y3;
    endfunction

endpackage

@@ design/ansipal_class16.sv @@
// 16-colour classifier: pixel to sgr code 30-37/90-97, shifted for background
module ansipal_class16
    import ansipal_pkg::*;
(
    input  chan_t      red,
    input  chan_t      green,
    input  chan_t      blue,
    input  logic       for_background,
    input  logic       force_bright,
    output logic [7:0] sgr_code
);

    chan_t       mx;
    chan_t       mn;
    chan_t       spread;
    logic [11:0] spread10;
    logic [9:0]  sum;
    logic        bright;
    logic        gray;
    logic        red_dom;
    logic        green_dom;
    color_t      color;
    logic [7:0]  base;

    // extremes and sum of the channels
    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        spread   = mx - mn;
        spread10 = {1'b0, spread, 3'b000} + {3'b000, spread, 1'b0};
        sum      = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    end

    // brightness and low-saturation tests
    assign bright = force_bright || (sum > SUM_BRIGHT);
    assign gray   = (mx == 8'd0) || (spread10 < {4'b0000, mx});

    // dominant channel, ties to red then green
    assign red_dom   = (red >= green) && (red >= blue);
    assign green_dom = (green >= red) && (green >= blue);

    // colour selection
    always_comb
    begin
        if (gray)
            color = (sum > SUM_WHITE) ? COLOR_WHITE : COLOR_BLACK;
        else if (red_dom)
        begin
            if ((green > blue) && over_six_tenths(green, red))
                color = COLOR_YELLOW;
            else if (over_six_tenths(blue, red))
                color = COLOR_MAGENTA;
            else
                color = COLOR_RED;
        end
        else if (green_dom)
        begin
            if ((red > blue) && over_six_tenths(red, green))
                color = COLOR_YELLOW;
            else if (over_six_tenths(blue, green))
                color = COLOR_CYAN;
            else
                color = COLOR_GREEN;
        end
        else
        begin
            if ((red > green) && over_six_tenths(red, blue))
                color = COLOR_MAGENTA;
            else if (over_six_tenths(green, blue))
                color = COLOR_CYAN;
            else
                color = COLOR_BLUE;
        end
    end

    // sgr code with background shift
    assign base     = bright ? SGR_BRIGHT_BASE : SGR_NORMAL_BASE;
    assign sgr_code = base + {5'b00000, color} + (for_background ? SGR_BG_OFFSET : 8'd0);

endmodule

@@ design/ansipal_index256.sv @@
// 256-colour index: gray ramp for equal channels, 6x6x6 cube otherwise
module ansipal_index256
    import ansipal_pkg::*;
(
    input  chan_t      red,
    input  chan_t      green,
    input  chan_t      blue,
    output logic [7:0] palette_index
);

    chan_t       ramp_off;
    logic [15:0] ramp_prod;
    logic [4:0]  ramp_step;
    logic [2:0]  dr;
    logic [2:0]  dg;
    logic [2:0]  db;
    logic [7:0]  cube_index;
    logic [7:0]  ramp_index;

    // ramp step (v-8)/10 as (x*205)>>11, exact for x below 1029
    always_comb
    begin
        ramp_off  = red - RAMP_LOW;
        ramp_prod = {8'd0, ramp_off} * 16'd205;
        ramp_step = ramp_prod[15:11];
    end

    // ramp entry with the top step saturated, cube black or white outside the ramp range
    always_comb
    begin
        if (red < RAMP_LOW)
            ramp_index = IDX_CUBE_BASE;
        else if (red > RAMP_HIGH)
            ramp_index = IDX_CUBE_TOP;
        else if (ramp_step >= RAMP_STEP_LAST)
            ramp_index = IDX_RAMP_SAT;
        else
            ramp_index = IDX_RAMP_BASE + {3'b000, ramp_step};
    end

    // cube coordinates and index
    always_comb
    begin
        dr = cube_digit(red);
        dg = cube_digit(green);
        db = cube_digit(blue);
        cube_index = IDX_CUBE_BASE + ({5'b00000, dr} * 8'd36)
                   + ({5'b00000, dg} * 8'd6) + {5'b00000, db};
    end

    assign palette_index = ((red == green) && (green == blue)) ? ramp_index : cube_index;

endmodule

@@ design/rgb_to_ansi_palette_code.sv @@
// top level: pixel to ansi palette code, input register, one logic pass, result register
//
// Takes one pixel item per clock while in_ready is high and returns one code item per
// pixel, passing through the input register and then the result register. The pixel
// is registered on acceptance, both the 16-colour classifier and the 256-colour index
// are worked out from that register in one pass, and the chosen code is held in the
// result register until taken. in_ready stays high while the result register is free
// or being emptied, so a full pipe of two items keeps one item per cycle flowing.
// palette_mode resets to 1 (256-colour) and is written by palette_mode_we; write
// it only while no item is in flight.
module rgb_to_ansi_palette_code
    import ansipal_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       palette_mode_we,
    input  logic       palette_mode_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       for_background,
    input  logic       force_bright,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] color_code,
    output logic [1:0] code_kind
);

`include "rgb_to_ansi_palette_code_defines.svh"

    logic       palette_mode_reg;
    logic       stage_valid_reg;
    logic       out_valid_reg;
    chan_t      red_reg;
    chan_t      green_reg;
    chan_t      blue_reg;
    logic       bg_reg;
    logic       bright_reg;
    logic       stage_move;
    logic [7:0] sgr_code;
    logic [7:0] palette_index;
    result_t    result_next;
    result_t    result_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            palette_mode_reg <= MODE_256;
        else if (palette_mode_we)
            palette_mode_reg <= palette_mode_wdata;
    end

    // flow control
    assign stage_move = !out_valid_reg || out_ready;
    assign in_ready   = !stage_valid_reg || stage_move;

    // input register valid and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                stage_valid_reg <= in_valid;
            if (stage_move)
                out_valid_reg <= stage_valid_reg;
        end
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            red_reg    <= red;
            green_reg  <= green;
            blue_reg   <= blue;
            bg_reg     <= for_background;
            bright_reg <= force_bright;
        end
    end

    // 16-colour classification
    ansipal_class16 u_class16 (
        .red            (red_reg),
        .green          (green_reg),
        .blue           (blue_reg),
        .for_background (bg_reg),
        .force_bright   (bright_reg),
        .sgr_code       (sgr_code)
    );

    // 256-colour index
    ansipal_index256 u_index256 (
        .red           (red_reg),
        .green         (green_reg),
        .blue          (blue_reg),
        .palette_index (palette_index)
    );

    // mode select
    always_comb
    begin
        if (palette_mode_reg == MODE_16)
        begin
            result_next.color_code = sgr_code;
            result_next.code_kind  = KIND_DIRECT;
        end
        else
        begin
            result_next.color_code = palette_index;
            result_next.code_kind  = bg_reg ? KIND_BG_IDX : KIND_FG_IDX;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (stage_move && stage_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign color_code = result_reg.color_code;
    assign code_kind  = result_reg.code_kind;

    // checks
    `ANSIPAL_ASSERT_NEXT(a_stage_held, stage_valid_reg && !stage_move, stage_valid_reg, "pixel item dropped while result stalled")
    `ANSIPAL_ASSERT_NOW(a_kind_legal, out_valid_reg, code_kind == KIND_DIRECT || code_kind == KIND_FG_IDX || code_kind == KIND_BG_IDX, "unknown code kind")
    `ANSIPAL_ASSERT_NOW(a_sgr_range, out_valid_reg && code_kind == KIND_DIRECT, (color_code >= 8'd30 && color_code <= 8'd47) || (color_code >= 8'd90 && color_code <= 8'd107), "sgr code out of range")
    `ANSIPAL_ASSERT_NOW(a_index_range, out_valid_reg && code_kind != KIND_DIRECT, color_code >= IDX_CUBE_BASE, "palette index below the cube")

endmodule
